// File: src/strict_priority_multi_queue_defines.svh
// Assertion helpers for the queue RTL.
`ifndef STRICT_PRIORITY_MULTI_QUEUE_DEFINES_SVH
`define STRICT_PRIORITY_MULTI_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define SPMQ_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("spmq assertion failed");

// Next-cycle implication, disabled while reset is low.
`define SPMQ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("spmq assertion failed");

`endif

// File: src/spmq_pkg.sv
`timescale 1ns / 1ps

package spmq_pkg;

    localparam int LEVELS      = 5;
    localparam int QUEUE_DEPTH = 16;

    localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W = $clog2(LEVELS * QUEUE_DEPTH);
    localparam int ID_W   = 16;

    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_SERVE = 1'b1;

    typedef logic [LVL_W-1:0]  q_idx_t;
    typedef logic [PTR_W-1:0]  ptr_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [ID_W-1:0]   id_t;

    typedef enum logic [2:0] {
        ST_ADDED     = 3'd0,
        ST_BAD_LEVEL = 3'd1,
        ST_FULL      = 3'd2,
        ST_SERVED    = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

    // Result of one word's decision, handed to the output stage.
    typedef struct packed {
        status_t     status;
        logic [2:0]  served_level;
    } dec_t;

    // Circular pointer advance.
    function automatic ptr_t ptr_inc(input ptr_t p);
        ptr_t r;
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    // Flat memory address of one slot of one level.
    function automatic addr_t slot_addr(input q_idx_t q, input ptr_t p);
        int a;
        a = int'(q) * QUEUE_DEPTH + int'(p);
        return a[ADDR_W-1:0];
    endfunction

    // Level number as reported, masked to the 3-bit field.
    function automatic logic [2:0] level_out(input q_idx_t q);
        int v;
        v = int'(q) + 1;
        return v[2:0];
    endfunction

endpackage

// File: src/spmq_ram.sv
`timescale 1ns / 1ps

module spmq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 80
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port; read data holds between reads.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/spmq_ctrl.sv
`timescale 1ns / 1ps

module spmq_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic              func,
    input  logic [2:0]        level,
    input  spmq_pkg::id_t     entry_id,
    output spmq_pkg::dec_t    dec,
    output logic              ram_we,
    output spmq_pkg::addr_t   ram_waddr,
    output spmq_pkg::id_t     ram_wdata,
    output logic              ram_re,
    output spmq_pkg::addr_t   ram_raddr
);

    import spmq_pkg::*;

    ptr_t head_reg  [LEVELS];
    ptr_t tail_reg  [LEVELS];
    cnt_t count_reg [LEVELS];

    logic   [LEVELS-1:0] nonempty;
    logic                any_nonempty;
    q_idx_t              pick_q;
    q_idx_t              add_q;
    q_idx_t              sel_q;
    logic                level_ok;
    logic                sel_full;
    logic                do_push;
    logic                do_pop;
    int                  lvl_m1;

    // Occupancy flags and strict-priority pick, lowest level number wins.
    always_comb begin
        pick_q = '0;
        for (int i = LEVELS - 1; i >= 0; i--) begin
            nonempty[i] = (count_reg[i] != '0);
            if (nonempty[i]) begin
                pick_q = q_idx_t'(i);
            end
        end
    end

    assign any_nonempty = |nonempty;

    // Add level check and queue index.
    assign level_ok = (level != 3'd0) && (int'(level) <= LEVELS);
    assign lvl_m1   = int'(level) - 1;
    assign add_q    = lvl_m1[LVL_W-1:0];

    // One level is touched per word, so one read of the pointer state does.
    assign sel_q    = (func == FUNC_SERVE) ? pick_q : add_q;
    assign sel_full = (count_reg[sel_q] == CNT_W'(QUEUE_DEPTH));

    // Decision for this word.
    always_comb begin
        dec.status       = ST_ADDED;
        dec.served_level = 3'd0;
        do_push          = 1'b0;
        do_pop           = 1'b0;
        if (func == FUNC_ADD) begin
            priority if (!level_ok) begin
                dec.status = ST_BAD_LEVEL;
            end else if (sel_full) begin
                dec.status = ST_FULL;
            end else begin
                dec.status = ST_ADDED;
                do_push    = 1'b1;
            end
        end else begin
            if (any_nonempty) begin
                dec.status       = ST_SERVED;
                dec.served_level = level_out(pick_q);
                do_pop           = 1'b1;
            end else begin
                dec.status = ST_EMPTY;
            end
        end
    end

    // Entry memory access.
    assign ram_we    = accept && do_push;
    assign ram_waddr = slot_addr(sel_q, tail_reg[sel_q]);
    assign ram_wdata = entry_id;
    assign ram_re    = accept && do_pop;
    assign ram_raddr = slot_addr(sel_q, head_reg[sel_q]);

    // Pointer and fill count update.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LEVELS; i++) begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end else if (accept) begin
            if (do_push) begin
                tail_reg[sel_q]  <= ptr_inc(tail_reg[sel_q]);
                count_reg[sel_q] <= count_reg[sel_q] + 1'b1;
            end
            if (do_pop) begin
                head_reg[sel_q]  <= ptr_inc(head_reg[sel_q]);
                count_reg[sel_q] <= count_reg[sel_q] - 1'b1;
            end
        end
    end

endmodule

// File: src/strict_priority_multi_queue.sv
`timescale 1ns / 1ps
// Strict-priority queue with one FIFO per level (level 1 is served first).
// Every input word gives exactly one result word, in the cycle after it is
// accepted; a new word is accepted every cycle as long as the result side
// keeps up, so the sustained rate is one word per cycle. The combinational
// path is the priority pick over the level fill counts plus the pointer
// update; a served id comes out of the entry memory's registered read port.
// The entry memory is not cleared after reset and needs no clearing pass:
// only slots written by an add are ever read. Adds to a full level and adds
// with a level outside 1..LEVELS are dropped and flagged in the status.
`include "strict_priority_multi_queue_defines.svh"

module strict_priority_multi_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_func,
    input  logic [2:0]          s_level,
    input  spmq_pkg::id_t       s_entry_id,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [2:0]          m_status,
    output spmq_pkg::id_t       m_served_id,
    output logic [2:0]          m_served_level
);

    import spmq_pkg::*;

    logic       accept;
    dec_t       dec;
    logic       ram_we;
    addr_t      ram_waddr;
    id_t        ram_wdata;
    logic       ram_re;
    addr_t      ram_raddr;
    id_t        ram_rdata;

    logic       valid_reg;
    status_t    status_reg;
    logic [2:0] level_reg;

    // A word enters when the result slot is free or being emptied.
    assign s_ready = !valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    spmq_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .func      (s_func),
        .level     (s_level),
        .entry_id  (s_entry_id),
        .dec       (dec),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr)
    );

    spmq_ram #(
        .WIDTH (ID_W),
        .DEPTH (LEVELS * QUEUE_DEPTH)
    ) u_entry_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Result register; the memory read data lines up with it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (accept) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg <= dec.status;
            level_reg  <= dec.served_level;
        end
    end

    assign m_valid        = valid_reg;
    assign m_status       = status_reg;
    assign m_served_id    = (status_reg == ST_SERVED) ? ram_rdata : '0;
    assign m_served_level = level_reg;

    // Checks on result encoding.
    `SPMQ_ASSERT_NEXT(a_serve_result, aclk, aresetn, accept && (s_func == FUNC_SERVE),
        m_valid && ((m_status == ST_SERVED) || (m_status == ST_EMPTY)))
    `SPMQ_ASSERT_NEXT(a_add_result, aclk, aresetn, accept && (s_func == FUNC_ADD),
        m_valid && ((m_status == ST_ADDED) || (m_status == ST_BAD_LEVEL) ||
        (m_status == ST_FULL)))
    `SPMQ_ASSERT_NOW(a_level_only_served, aclk, aresetn, m_valid,
        (m_status == ST_SERVED) == (m_served_level != 3'd0))

endmodule
